// ----- design/lc3_subset_cpu_step_defines.svh -----
// ----------------------------------------------------------------------------
// lc3 subset cpu step: assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LC3_SUBSET_CPU_STEP_DEFINES_SVH
`define LC3_SUBSET_CPU_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define LC3_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lc3 cpu check failed");
`define LC3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lc3 cpu check failed");
`else
`define LC3_ASSERT_IMPL(lbl, ante, cons)
`define LC3_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/lc3_cpu_pkg.sv -----
// ----------------------------------------------------------------------------
// lc3 cpu package
// item codes, instruction opcodes, alu types and small helpers
// ----------------------------------------------------------------------------
package lc3_cpu_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam logic [15:0] START_PC_RESET = 16'h3000;

	typedef enum logic [1:0] {
		ITEM_WRITE   = 2'd0,
		ITEM_READ    = 2'd1,
		ITEM_EXEC    = 2'd2,
		ITEM_RESTART = 2'd3
	} item_op_t;

	localparam logic [3:0] OP_BR   = 4'h0;
	localparam logic [3:0] OP_ADD  = 4'h1;
	localparam logic [3:0] OP_LD   = 4'h2;
	localparam logic [3:0] OP_ST   = 4'h3;
	localparam logic [3:0] OP_AND  = 4'h5;
	localparam logic [3:0] OP_NOT  = 4'h9;
	localparam logic [3:0] OP_JMP  = 4'hC;
	localparam logic [3:0] OP_TRAP = 4'hF;

	localparam logic [7:0] TRAP_HALT = 8'h25;

	localparam logic [2:0] CC_N = 3'b100;
	localparam logic [2:0] CC_Z = 3'b010;
	localparam logic [2:0] CC_P = 3'b001;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_AND,
		ALU_NOT,
		ALU_PASS
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [15:0] a;
		logic [15:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] value;
		logic [2:0]  cc;
	} alu_res_t;

	function automatic logic [15:0] sext9(input logic [8:0] v);
		return {{7{v[8]}}, v};
	endfunction

	function automatic logic [15:0] sext5(input logic [4:0] v);
		return {{11{v[4]}}, v};
	endfunction

	function automatic alu_op_t alu_sel(input logic [3:0] op);
		alu_op_t r;
		case (op)
			OP_ADD: r = ALU_ADD;
			OP_AND: r = ALU_AND;
			OP_NOT: r = ALU_NOT;
			default: r = ALU_PASS;
		endcase
		return r;
	endfunction

endpackage

// ----- design/lc3_cpu_ram.sv -----
// ----------------------------------------------------------------------------
// lc3 cpu ram
// single port synchronous ram, registered read that holds when not enabled
// ----------------------------------------------------------------------------
module lc3_cpu_ram #(
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lc3_cpu_alu.sv -----
// ----------------------------------------------------------------------------
// lc3 cpu alu
// add, and, not or pass, with the nzp codes of the result
// ----------------------------------------------------------------------------
module lc3_cpu_alu import lc3_cpu_pkg::*; (
	input  alu_req_t req,
	output alu_res_t res
);

	logic [15:0] v;

	always_comb begin
		case (req.op)
			ALU_ADD:  v = req.a + req.b;
			ALU_AND:  v = req.a & req.b;
			ALU_NOT:  v = ~req.a;
			ALU_PASS: v = req.b;
			default:  v = req.b;
		endcase
		res.value = v;
		if (v[15]) begin
			res.cc = CC_N;
		end else if (v == 16'd0) begin
			res.cc = CC_Z;
		end else begin
			res.cc = CC_P;
		end
	end

endmodule

// ----- design/lc3_subset_cpu_step.sv -----
// ----------------------------------------------------------------------------
// lc3 subset cpu step: write, read, restart and halted execute go through fin; execute goes fetch, exec1
// (and exec2 for reg ADD/AND); one item at a time, in_stall until idle, as fetch, register and data share rams
// reset clears pc to 0x3000, cc to z, halt flag, register valid bits; main memory is not cleared
// ----------------------------------------------------------------------------
`include "lc3_subset_cpu_step_defines.svh"

module lc3_subset_cpu_step import lc3_cpu_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] address,
	input  logic [15:0] data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] read_data,
	output logic [15:0] pc,
	output logic [15:0] instruction,
	output logic [2:0]  cond_codes,
	output logic        halted
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIN,
		S_FETCH,
		S_EXEC1,
		S_EXEC2
	} state_t;

	state_t      state_q;
	item_op_t    item_op_q;
	logic [15:0] start_pc_q;
	logic [15:0] pc_q;
	logic [2:0]  cc_q;
	logic        halt_q;
	logic [15:0] ir_q;
	logic [15:0] ea_q;
	logic [15:0] a_q;
	logic [7:0]  rf_valid_q;
	logic [2:0]  rf_raddr_q;

	logic        out_valid_q;
	logic [15:0] read_data_q;
	logic [15:0] pc_out_q;
	logic [15:0] instr_q;
	logic [2:0]  cc_out_q;
	logic        halt_out_q;

	logic                 mem_we;
	logic                 mem_re;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [15:0]          mem_wdata;
	logic [15:0]          mem_rdata;

	logic        rf_we;
	logic        rf_re;
	logic [2:0]  rf_addr;
	logic [15:0] rf_wdata;
	logic [15:0] rf_rdata;

	alu_req_t    alu_req;
	alu_res_t    alu_res;

	logic [15:0] pc_nx;
	logic [2:0]  cc_nx;
	logic        halt_nx;
	logic [15:0] ra;
	logic [15:0] ea_fetch;
	logic [3:0]  ir_op;
	logic        need_b;
	logic        out_free;
	logic        in_acc;
	logic        done;

	lc3_cpu_ram #(.WIDTH(16), .ADDR_W(ADDR_BITS)) u_main_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	lc3_cpu_ram #(.WIDTH(16), .ADDR_W(3)) u_reg_file (
		.clk   (clk),
		.we    (rf_we),
		.re    (rf_re),
		.addr  (rf_addr),
		.wdata (rf_wdata),
		.rdata (rf_rdata)
	);

	lc3_cpu_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// registers never written since reset read as zero
	assign ra       = rf_valid_q[rf_raddr_q] ? rf_rdata : 16'd0;
	assign ir_op    = ir_q[15:12];
	assign need_b   = ((ir_op == OP_ADD) || (ir_op == OP_AND)) && !ir_q[5];
	assign ea_fetch = pc_q + 16'd1 + sext9(mem_rdata[8:0]);

	assign done = out_free && ((state_q == S_FIN) || (state_q == S_EXEC2) ||
		((state_q == S_EXEC1) && !need_b));

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = address[ADDR_BITS-1:0];
		mem_wdata = data;
		rf_we     = 1'b0;
		rf_re     = 1'b0;
		rf_addr   = ir_q[11:9];
		rf_wdata  = alu_res.value;
		pc_nx     = pc_q;
		cc_nx     = cc_q;
		halt_nx   = halt_q;
		alu_req.op = ALU_PASS;
		alu_req.a  = ra;
		alu_req.b  = mem_rdata;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (item_op_t'(opcode))
						ITEM_WRITE: mem_we = 1'b1;
						ITEM_READ:  mem_re = 1'b1;
						ITEM_EXEC: begin
							if (!halt_q) begin
								mem_re   = 1'b1;
								mem_addr = pc_q[ADDR_BITS-1:0];
							end
						end
						ITEM_RESTART: begin
							pc_nx   = start_pc_q;
							halt_nx = 1'b0;
						end
						default: ;
					endcase
				end
			end
			S_FETCH: begin
				// mem_rdata holds the instruction word
				pc_nx = pc_q + 16'd1;
				rf_re = 1'b1;
				rf_addr = (mem_rdata[15:12] == OP_ST) ? mem_rdata[11:9] : mem_rdata[8:6];
				if (mem_rdata[15:12] == OP_LD) begin
					mem_re   = 1'b1;
					mem_addr = ea_fetch[ADDR_BITS-1:0];
				end
			end
			S_EXEC1: begin
				if (need_b) begin
					rf_re   = 1'b1;
					rf_addr = ir_q[2:0];
				end else begin
					alu_req.op = alu_sel(ir_op);
					alu_req.b  = (ir_op == OP_LD) ? mem_rdata : sext5(ir_q[4:0]);
					if (out_free) begin
						case (ir_op) inside
							OP_ADD, OP_AND, OP_NOT, OP_LD: begin
								rf_we = 1'b1;
								cc_nx = alu_res.cc;
							end
							OP_ST: begin
								mem_we    = 1'b1;
								mem_addr  = ea_q[ADDR_BITS-1:0];
								mem_wdata = ra;
							end
							OP_JMP: pc_nx = ra;
							OP_BR: begin
								if ((ir_q[11:9] & cc_q) != 3'd0) begin
									pc_nx = ea_q;
								end
							end
							OP_TRAP: begin
								if (ir_q[7:0] == TRAP_HALT) begin
									halt_nx = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			S_EXEC2: begin
				alu_req.op = alu_sel(ir_op);
				alu_req.a  = a_q;
				alu_req.b  = ra;
				if (out_free) begin
					rf_we = 1'b1;
					cc_nx = alu_res.cc;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_pc_q  <= START_PC_RESET;
			pc_q        <= START_PC_RESET;
			cc_q        <= CC_Z;
			halt_q      <= 1'b0;
			rf_valid_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_pc_q <= cfg_wdata;
			end
			pc_q   <= pc_nx;
			cc_q   <= cc_nx;
			halt_q <= halt_nx;
			if (rf_we) begin
				rf_valid_q[rf_addr] <= 1'b1;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if ((item_op_t'(opcode) == ITEM_EXEC) && !halt_q) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FETCH: state_q <= S_EXEC1;
				S_EXEC1: begin
					if (need_b) begin
						state_q <= S_EXEC2;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EXEC2, S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_op_q <= item_op_t'(opcode);
		end
		if (state_q == S_FETCH) begin
			ir_q <= mem_rdata;
			ea_q <= ea_fetch;
		end
		if ((state_q == S_EXEC1) && need_b) begin
			a_q <= ra;
		end
		if (rf_re) begin
			rf_raddr_q <= rf_addr;
		end
		if (done) begin
			read_data_q <= ((state_q == S_FIN) && (item_op_q == ITEM_READ)) ? mem_rdata : 16'd0;
			pc_out_q    <= pc_nx;
			instr_q     <= (state_q == S_FIN) ? 16'd0 : ir_q;
			cc_out_q    <= cc_nx;
			halt_out_q  <= halt_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign pc          = pc_out_q;
	assign instruction = instr_q;
	assign cond_codes  = cc_out_q;
	assign halted      = halt_out_q;

	`LC3_ASSERT_NEXT(a_halted_exec_holds_pc, in_acc && (opcode == ITEM_EXEC) && halt_q, (pc_q == $past(pc_q)) && (state_q == S_FIN))
	`LC3_ASSERT_NEXT(a_restart_loads_pc, in_acc && (opcode == ITEM_RESTART), (pc_q == $past(start_pc_q)) && !halt_q)
	`LC3_ASSERT_IMPL(a_rf_write_in_exec, rf_we, (state_q == S_EXEC1) || (state_q == S_EXEC2))

endmodule
